// ----- src/ssd_pkg.sv -----
// Shared types, bus command constants and segment table for the display frame encoder.
package ssd_pkg;

    typedef enum logic [1:0] {
        TOK_START = 2'd0,
        TOK_DATA  = 2'd1,
        TOK_ACK   = 2'd2,
        TOK_STOP  = 2'd3
    } kind_t;

    localparam logic OP_SHOW   = 1'b0;
    localparam logic OP_BRIGHT = 1'b1;

    localparam logic [7:0] CMD_AUTO_INC  = 8'h40;
    localparam logic [7:0] CMD_ADDR0     = 8'hC0;
    localparam logic [7:0] CMD_CTRL_BASE = 8'h87;
    localparam logic [7:0] SEG_DP        = 8'h80;

    localparam logic [13:0] MOD_BASE  = 14'd10000;
    localparam logic [25:0] RECIP_TEN = 26'd3277;

    localparam logic [3:0] DISPLAY_LAST_TOK = 4'd15;
    localparam logic [3:0] BRIGHT_LAST_TOK  = 4'd3;

    typedef struct packed {
        logic            bright;
        logic [3:0][7:0] bytes;
    } frame_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_SPLIT,
        FS_PUSH
    } front_state_t;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'h3f;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5b;
            4'd3:    code = 8'h4f;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6d;
            4'd6:    code = 8'h7d;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7f;
            4'd9:    code = 8'h6f;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

// ----- src/ssd_front.sv -----
// Request intake: splits display values into segment bytes and builds frame descriptors.
module ssd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,
    input  logic                s_tuser,
    input  logic [3:0]          brightness,
    output logic                push,
    output ssd_pkg::frame_t     push_frame,
    input  logic                q_full
);
    import ssd_pkg::*;

    front_state_t    state_reg, state_next;
    logic [13:0]     v_reg, v_next;
    logic [1:0]      step_reg, step_next;
    logic [3:0][7:0] seg_reg, seg_next;
    logic            bright_reg, bright_next;
    logic            colon_reg, colon_next;

    logic        accept;
    logic [13:0] in_value;
    logic [13:0] in_mod;
    logic [25:0] prod;
    logic [9:0]  quot;
    logic [13:0] quot_ext;
    logic [13:0] quot_x10;
    logic [13:0] rem_full;
    logic [7:0]  seg_byte;

    assign accept   = s_tvalid && s_tready;
    assign in_value = s_tdata[13:0];
    assign in_mod   = (in_value >= MOD_BASE) ? (in_value - MOD_BASE) : in_value;

    assign prod     = {12'b0, v_reg} * RECIP_TEN;
    assign quot     = prod[24:15];
    assign quot_ext = {4'b0, quot};
    assign quot_x10 = (quot_ext << 3) + (quot_ext << 1);
    assign rem_full = v_reg - quot_x10;
    assign seg_byte = seg_code(rem_full[3:0]) |
                      ((colon_reg && (step_reg == 2'd2)) ? SEG_DP : 8'h00);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser == OP_BRIGHT) ? FS_PUSH : FS_SPLIT;
                end
            end
            FS_SPLIT: begin
                if (step_reg == 2'd3) begin
                    state_next = FS_PUSH;
                end
            end
            FS_PUSH: begin
                if (!q_full) begin
                    state_next = FS_IDLE;
                end
            end
            default: state_next = FS_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        push     = 1'b0;
        case (state_reg)
            FS_IDLE:  s_tready = 1'b1;
            FS_SPLIT: s_tready = 1'b0;
            FS_PUSH:  push     = !q_full;
            default:  s_tready = 1'b0;
        endcase
    end

    always_comb begin
        v_next      = v_reg;
        step_next   = step_reg;
        seg_next    = seg_reg;
        bright_next = bright_reg;
        colon_next  = colon_reg;
        case (state_reg)
            FS_IDLE: begin
                if (accept) begin
                    v_next      = in_mod;
                    step_next   = 2'd0;
                    colon_next  = s_tdata[14];
                    bright_next = (s_tuser == OP_BRIGHT);
                    seg_next[0] = CMD_CTRL_BASE + {4'b0, brightness};
                end
            end
            FS_SPLIT: begin
                seg_next[step_reg] = seg_byte;
                v_next             = quot_ext;
                step_next          = step_reg + 2'd1;
            end
            default: begin
                v_next = v_reg;
            end
        endcase
    end

    assign push_frame.bright = bright_reg;
    assign push_frame.bytes  = seg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        v_reg      <= v_next;
        step_reg   <= step_next;
        seg_reg    <= seg_next;
        bright_reg <= bright_next;
        colon_reg  <= colon_next;
    end

endmodule

// ----- src/ssd_queue.sv -----
// Small register queue of frame descriptors between intake and token emitter.
module ssd_queue #(
    parameter int DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ssd_pkg::frame_t push_frame,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output ssd_pkg::frame_t head
);
    import ssd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    frame_t          slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

// ----- src/ssd_back.sv -----
// Token emitter: walks each frame descriptor and drives the registered token output.
module ssd_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  ssd_pkg::frame_t frame,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);
    import ssd_pkg::*;

    logic [3:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    kind_t      kind_reg, kind_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;

    kind_t      tok_kind;
    logic [7:0] tok_byte;
    logic       tok_last;
    logic       load;

    assign load = q_valid && (!valid_reg || m_tready);
    assign pop  = load && tok_last;

    always_comb begin
        tok_kind = TOK_START;
        tok_byte = 8'h00;
        if (frame.bright) begin
            tok_last = (idx_reg == BRIGHT_LAST_TOK);
            case (idx_reg)
                4'd0: tok_kind = TOK_START;
                4'd1: begin
                    tok_kind = TOK_DATA;
                    tok_byte = frame.bytes[0];
                end
                4'd2:    tok_kind = TOK_ACK;
                default: tok_kind = TOK_STOP;
            endcase
        end else begin
            tok_last = (idx_reg == DISPLAY_LAST_TOK);
            case (idx_reg)
                4'd0: tok_kind = TOK_START;
                4'd1: begin
                    tok_kind = TOK_DATA;
                    tok_byte = CMD_AUTO_INC;
                end
                4'd2: tok_kind = TOK_ACK;
                4'd3: tok_kind = TOK_STOP;
                4'd4: tok_kind = TOK_START;
                4'd5: begin
                    tok_kind = TOK_DATA;
                    tok_byte = CMD_ADDR0;
                end
                4'd7: begin
                    tok_kind = TOK_DATA;
                    tok_byte = frame.bytes[3];
                end
                4'd9: begin
                    tok_kind = TOK_DATA;
                    tok_byte = frame.bytes[2];
                end
                4'd11: begin
                    tok_kind = TOK_DATA;
                    tok_byte = frame.bytes[1];
                end
                4'd13: begin
                    tok_kind = TOK_DATA;
                    tok_byte = frame.bytes[0];
                end
                4'd6, 4'd8, 4'd10, 4'd12, 4'd14: tok_kind = TOK_ACK;
                default: tok_kind = TOK_STOP;
            endcase
        end
    end

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            kind_next  = tok_kind;
            byte_next  = tok_byte;
            last_next  = tok_last;
            idx_next   = tok_last ? 4'd0 : idx_reg + 4'd1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

endmodule

// ----- src/seven_segment_display_frame_encoder.sv -----
// Top level of the four-digit seven-segment display frame encoder.
//
// Each accepted request becomes a stream of two-wire bus words, one word per
// cycle on the master side when m_tready stays high and a frame is queued: a
// display request makes 16 words (start, 0x40, ack, stop, start, 0xC0, ack,
// four digit bytes with acks, stop), a brightness request makes 4 words
// (start, 0x87 + brightness, ack, stop). The intake splits a display value
// into digits, one digit per cycle, and takes no new request until it has
// pushed the frame of the last one; a queue of QUEUE_DEPTH frames lets it
// work ahead of the emitter. Brightness is sampled when a brightness
// request is taken in; m_tlast marks the final word of each request.
module seven_segment_display_frame_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,   // brightness
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // [13:0] value, [14] colon, [15] zero
    input  logic        s_tuser,       // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // [7:0] data_byte
    output logic [1:0]  m_tuser,       // [1:0] kind
    output logic        m_tlast
);
    import ssd_pkg::*;

    logic [3:0] brightness_reg;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_valid;
    frame_t     push_frame;
    frame_t     head_frame;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= 4'd7;
        end else if (cfg_wr_en) begin
            brightness_reg <= cfg_wr_data;
        end
    end

    ssd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .brightness (brightness_reg),
        .push       (push),
        .push_frame (push_frame),
        .q_full     (q_full)
    );

    ssd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_frame (push_frame),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_valid),
        .head       (head_frame)
    );

    ssd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .frame    (head_frame),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
